[rtl/lav_pkg.sv]
package lav_pkg;

  localparam int MAG_W    = 64;
  localparam int POS_W    = 6;
  localparam int SCALED_W = 30;

  // position of the leading one
  function automatic logic [POS_W-1:0] top_bit(input logic [MAG_W-1:0] m);
    logic [POS_W-1:0] p;
    p = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (m[i]) p = POS_W'(i);
    end
    return p;
  endfunction

  // shift so that a leading one at p lands on the top scaled bit
  function automatic logic [SCALED_W-1:0] scale_mag(input logic [MAG_W-1:0] m,
                                                    input logic [POS_W-1:0] p);
    logic [MAG_W-1:0] s;
    if (p >= POS_W'(SCALED_W)) begin
      s = m >> (p - POS_W'(SCALED_W - 1));
    end else begin
      s = m << (POS_W'(SCALED_W - 1) - p);
    end
    return s[SCALED_W-1:0];
  endfunction

endpackage

[rtl/lav_unitize.sv]
module lav_unitize #(
  parameter int IN_W      = 33,
  parameter int FRAC_BITS = 16,
  parameter int SIDE_W    = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic signed [IN_W-1:0]      v [3],
  input  logic [SIDE_W-1:0]           side_in,
  output logic                        out_valid,
  output logic signed [FRAC_BITS+1:0] u [3],
  output logic                        zero,
  output logic [SIDE_W-1:0]           side_out
);

  localparam int SW     = lav_pkg::SCALED_W;
  localparam int MAG_W  = lav_pkg::MAG_W;
  localparam int POS_W  = lav_pkg::POS_W;
  localparam int L_W    = 2 * SW + 2;
  localparam int ROOT_W = SW + 1;
  localparam int NUM_W  = SW + FRAC_BITS + 1;
  localparam int QUO_W  = FRAC_BITS + 1;
  localparam int U_W    = FRAC_BITS + 2;

  typedef struct packed {
    logic [2:0][SW-1:0] w;
    logic [2:0]         neg;
    logic               zero;
    logic [SIDE_W-1:0]  side;
  } carry_t;

  // magnitudes
  logic              v1;
  logic [IN_W-1:0]   m1 [3];
  logic [2:0]        n1;
  logic [SIDE_W-1:0] s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        n1[i] <= v[i][IN_W-1];
        m1[i] <= v[i][IN_W-1] ? IN_W'(-v[i]) : IN_W'(v[i]);
      end
      s1 <= side_in;
    end
  end

  // leading one of the largest magnitude
  logic              v2;
  logic [POS_W-1:0]  p2;
  logic              z2;
  logic [IN_W-1:0]   m2 [3];
  logic [2:0]        n2;
  logic [SIDE_W-1:0] s2;
  logic [IN_W-1:0]   orv;

  assign orv = m1[0] | m1[1] | m1[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      p2 <= lav_pkg::top_bit(MAG_W'(orv));
      z2 <= (orv == '0);
      m2 <= m1;
      n2 <= n1;
      s2 <= s1;
    end
  end

  // block scaling
  logic   v3;
  carry_t c3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        c3.w[i] <= lav_pkg::scale_mag(MAG_W'(m2[i]), p2);
      end
      c3.neg  <= n2;
      c3.zero <= z2;
      c3.side <= s2;
    end
  end

  // squares
  logic          v4;
  carry_t        c4;
  logic [2*SW-1:0] sq4 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq4[i] <= c3.w[i] * c3.w[i];
      end
      c4 <= c3;
    end
  end

  // square root, one result bit a stage
  logic              sq_v [ROOT_W+1];
  logic [L_W-1:0]    sq_x [ROOT_W+1];
  logic [ROOT_W-1:0] sq_q [ROOT_W+1];
  carry_t            sq_c [ROOT_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= v4;
    end
    if (en) begin
      sq_x[0] <= L_W'(sq4[0]) + L_W'(sq4[1]) + L_W'(sq4[2]);
      sq_q[0] <= '0;
      sq_c[0] <= c4;
    end
  end

  for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
    localparam int K = ROOT_W - 1 - g;
    logic [L_W-1:0] dt;
    logic           ge;

    assign dt = (L_W'(sq_q[g]) << (K + 1)) | (L_W'(1) << (2 * K));
    assign ge = (sq_x[g] >= dt);

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[g+1] <= 1'b0;
      end else if (en) begin
        sq_v[g+1] <= sq_v[g];
      end
      if (en) begin
        sq_x[g+1] <= ge ? sq_x[g] - dt : sq_x[g];
        sq_q[g+1] <= ge ? (sq_q[g] | (ROOT_W'(1) << K)) : sq_q[g];
        sq_c[g+1] <= sq_c[g];
      end
    end
  end

  // restoring division, one quotient bit a stage
  logic              dv_v   [QUO_W+1];
  logic [ROOT_W-1:0] dv_r   [QUO_W+1];
  logic [NUM_W-1:0]  dv_rem [QUO_W+1][3];
  logic [QUO_W-1:0]  dv_quo [QUO_W+1][3];
  carry_t            dv_c   [QUO_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= sq_v[ROOT_W];
    end
    if (en) begin
      dv_r[0] <= sq_q[ROOT_W];
      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i] <= (NUM_W'(sq_c[ROOT_W].w[i]) << FRAC_BITS)
                      + NUM_W'(sq_q[ROOT_W] >> 1);
        dv_quo[0][i] <= '0;
      end
      dv_c[0] <= sq_c[ROOT_W];
    end
  end

  for (genvar g = 0; g < QUO_W; g++) begin : g_div
    localparam int J = QUO_W - 1 - g;
    logic [NUM_W-1:0] ds;
    logic [2:0]       ge;

    assign ds = NUM_W'(dv_r[g]) << J;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        ge[i] = (dv_rem[g][i] >= ds);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[g+1] <= 1'b0;
      end else if (en) begin
        dv_v[g+1] <= dv_v[g];
      end
      if (en) begin
        dv_r[g+1] <= dv_r[g];
        for (int i = 0; i < 3; i++) begin
          dv_rem[g+1][i] <= ge[i] ? dv_rem[g][i] - ds : dv_rem[g][i];
          dv_quo[g+1][i] <= ge[i] ? (dv_quo[g][i] | (QUO_W'(1) << J)) : dv_quo[g][i];
        end
        dv_c[g+1] <= dv_c[g];
      end
    end
  end

  // sign and zero-length result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_v[QUO_W];
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_c[QUO_W].zero) begin
          u[i] <= '0;
        end else if (dv_c[QUO_W].neg[i]) begin
          u[i] <= -U_W'(dv_quo[QUO_W][i]);
        end else begin
          u[i] <= U_W'(dv_quo[QUO_W][i]);
        end
      end
      zero     <= dv_c[QUO_W].zero;
      side_out <= dv_c[QUO_W].side;
    end
  end

endmodule

[rtl/look_at_view_matrix.sv]
// columns: each word leaves the column output register as four columns, index 0 first; the other three columns
// follow one a cycle while column_stall is low
// throughput: a new word enters the column output register when the last column of the one before is taken;
// the square root and division pipelines take a new word every cycle unless the output register stalls them
// reset: synchronous, clears every valid bit and the column count; data registers keep
// the input is stalled while reset is high
module look_at_view_matrix #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [31:0] eye_x,
  input  logic [31:0] eye_y,
  input  logic [31:0] eye_z,
  input  logic [31:0] target_x,
  input  logic [31:0] target_y,
  input  logic [31:0] target_z,
  input  logic [31:0] upward_x,
  input  logic [31:0] upward_y,
  input  logic [31:0] upward_z,
  output logic        column_valid,
  input  logic        column_stall,
  output logic [1:0]  column_index,
  output logic [31:0] entry_row0,
  output logic [31:0] entry_row1,
  output logic [31:0] entry_row2,
  output logic [31:0] entry_row3,
  output logic        degenerate,
  output logic        saturated,
  output logic        last_column
);

  localparam int CW    = COORD_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int MAG_W = lav_pkg::MAG_W;
  localparam int SW    = lav_pkg::SCALED_W;
  localparam int D_W   = CW + 1;
  localparam int US_W  = SW + 1;
  localparam int Z_W   = F + 2;
  localparam int PR_W  = US_W + Z_W;
  localparam int CP_W  = PR_W + 1;
  localparam int YP_W  = 2 * Z_W;
  localparam int YD_W  = YP_W + 1;
  localparam int R_W   = F + 5;
  localparam int EW_W  = CW + F;
  localparam int WP_W  = R_W + CW;
  localparam int WS_W  = WP_W + 2;
  localparam int FP_W  = R_W + F + 1;
  localparam int FS_W  = FP_W + 2;
  localparam int T_W   = CW + F + 10;
  localparam logic [1:0] LAST_COL = 2'd3;

  localparam logic signed [YD_W-1:0] HALF_Y = YD_W'(1) <<< (F - 1);
  localparam logic signed [FS_W-1:0] HALF_F = FS_W'(1) <<< (F - 1);
  localparam logic signed [T_W-1:0]  HI_T   = (T_W'(1) <<< (CW - 1)) - T_W'(1);
  localparam logic signed [T_W-1:0]  LO_T   = -HI_T - T_W'(1);
  localparam logic signed [T_W-1:0]  ONE_T  = T_W'(1) <<< F;

  typedef struct packed {
    logic signed [CW-1:0]   e0;
    logic signed [CW-1:0]   e1;
    logic signed [CW-1:0]   e2;
    logic signed [US_W-1:0] u0;
    logic signed [US_W-1:0] u1;
    logic signed [US_W-1:0] u2;
  } side1_t;

  typedef struct packed {
    logic signed [CW-1:0]  e0;
    logic signed [CW-1:0]  e1;
    logic signed [CW-1:0]  e2;
    logic signed [Z_W-1:0] z0;
    logic signed [Z_W-1:0] z1;
    logic signed [Z_W-1:0] z2;
    logic                  zero;
  } side2_t;

  logic en;
  logic ser_free;

  // input words as coordinates
  logic [31:0]          port_w [9];
  logic [MAG_W-1:0]     ext    [9];
  logic signed [CW-1:0] in_c   [9];
  logic [CW-1:0]        up_m   [3];

  assign port_w[0] = eye_x;
  assign port_w[1] = eye_y;
  assign port_w[2] = eye_z;
  assign port_w[3] = target_x;
  assign port_w[4] = target_y;
  assign port_w[5] = target_z;
  assign port_w[6] = upward_x;
  assign port_w[7] = upward_y;
  assign port_w[8] = upward_z;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      ext[i]  = MAG_W'(port_w[i]);
      in_c[i] = ext[i][CW-1:0];
    end
    for (int i = 0; i < 3; i++) begin
      up_m[i] = in_c[6+i][CW-1] ? CW'(-in_c[6+i]) : CW'(in_c[6+i]);
    end
  end

  // stage a: forward difference, up magnitudes
  logic                  a_valid;
  logic signed [CW-1:0]  a_eye [3];
  logic signed [D_W-1:0] a_dif [3];
  logic [CW-1:0]         a_um  [3];
  logic [2:0]            a_un;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= item_valid;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_eye[i] <= in_c[i];
        a_dif[i] <= D_W'(in_c[i]) - D_W'(in_c[3+i]);
        a_um[i]  <= up_m[i];
        a_un[i]  <= in_c[6+i][CW-1];
      end
    end
  end

  // stage b: leading one of up
  logic                       b_valid;
  logic signed [CW-1:0]       b_eye [3];
  logic signed [D_W-1:0]      b_dif [3];
  logic [CW-1:0]              b_um  [3];
  logic [2:0]                 b_un;
  logic [lav_pkg::POS_W-1:0]  b_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
    if (en) begin
      b_p   <= lav_pkg::top_bit(MAG_W'(a_um[0] | a_um[1] | a_um[2]));
      b_eye <= a_eye;
      b_dif <= a_dif;
      b_um  <= a_um;
      b_un  <= a_un;
    end
  end

  // stage c: up block scaled
  logic                   c_valid;
  logic signed [CW-1:0]   c_eye [3];
  logic signed [D_W-1:0]  c_dif [3];
  logic signed [US_W-1:0] c_us  [3];
  side1_t                 c_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        c_us[i] <= b_un[i] ? -US_W'(lav_pkg::scale_mag(MAG_W'(b_um[i]), b_p))
                           :  US_W'(lav_pkg::scale_mag(MAG_W'(b_um[i]), b_p));
      end
      c_eye <= b_eye;
      c_dif <= b_dif;
    end
  end

  assign c_side = '{e0: c_eye[0], e1: c_eye[1], e2: c_eye[2],
                    u0: c_us[0], u1: c_us[1], u2: c_us[2]};

  // forward axis
  logic                  u1_valid;
  logic signed [Z_W-1:0] u1_z [3];
  logic                  u1_zero;
  logic [$bits(side1_t)-1:0] u1_side_w;
  side1_t                u1_side;

  lav_unitize #(
    .IN_W      (D_W),
    .FRAC_BITS (F),
    .SIDE_W    ($bits(side1_t))
  ) u_fwd (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (c_valid),
    .v         (c_dif),
    .side_in   (c_side),
    .out_valid (u1_valid),
    .u         (u1_z),
    .zero      (u1_zero),
    .side_out  (u1_side_w)
  );

  assign u1_side = side1_t'(u1_side_w);

  // stage e1: up cross z products
  logic                   e1_valid;
  logic signed [PR_W-1:0] e1_pr [6];
  side2_t                 e1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_valid <= 1'b0;
    end else if (en) begin
      e1_valid <= u1_valid;
    end
    if (en) begin
      e1_pr[0] <= PR_W'(u1_side.u1) * PR_W'(u1_z[2]);
      e1_pr[1] <= PR_W'(u1_side.u2) * PR_W'(u1_z[1]);
      e1_pr[2] <= PR_W'(u1_side.u2) * PR_W'(u1_z[0]);
      e1_pr[3] <= PR_W'(u1_side.u0) * PR_W'(u1_z[2]);
      e1_pr[4] <= PR_W'(u1_side.u0) * PR_W'(u1_z[1]);
      e1_pr[5] <= PR_W'(u1_side.u1) * PR_W'(u1_z[0]);
      e1_side  <= '{e0: u1_side.e0, e1: u1_side.e1, e2: u1_side.e2,
                    z0: u1_z[0], z1: u1_z[1], z2: u1_z[2], zero: u1_zero};
    end
  end

  // stage e2: cross differences
  logic                   e2_valid;
  logic signed [CP_W-1:0] e2_c [3];
  side2_t                 e2_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      e2_valid <= 1'b0;
    end else if (en) begin
      e2_valid <= e1_valid;
    end
    if (en) begin
      e2_c[0] <= CP_W'(e1_pr[0]) - CP_W'(e1_pr[1]);
      e2_c[1] <= CP_W'(e1_pr[2]) - CP_W'(e1_pr[3]);
      e2_c[2] <= CP_W'(e1_pr[4]) - CP_W'(e1_pr[5]);
      e2_side <= e1_side;
    end
  end

  // right axis
  logic                  u2_valid;
  logic signed [Z_W-1:0] u2_x [3];
  logic                  u2_zero;
  logic [$bits(side2_t)-1:0] u2_side_w;
  side2_t                u2_side;

  lav_unitize #(
    .IN_W      (CP_W),
    .FRAC_BITS (F),
    .SIDE_W    ($bits(side2_t))
  ) u_right (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (e2_valid),
    .v         (e2_c),
    .side_in   (e2_side),
    .out_valid (u2_valid),
    .u         (u2_x),
    .zero      (u2_zero),
    .side_out  (u2_side_w)
  );

  assign u2_side = side2_t'(u2_side_w);

  // stage f1: z cross x products
  logic                   f1_valid;
  logic signed [YP_W-1:0] f1_pr [6];
  logic signed [Z_W-1:0]  f1_x  [3];
  logic signed [Z_W-1:0]  f1_z  [3];
  logic signed [CW-1:0]   f1_eye [3];
  logic                   f1_degen;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= u2_valid;
    end
    if (en) begin
      f1_pr[0]  <= YP_W'(u2_side.z1) * YP_W'(u2_x[2]);
      f1_pr[1]  <= YP_W'(u2_side.z2) * YP_W'(u2_x[1]);
      f1_pr[2]  <= YP_W'(u2_side.z2) * YP_W'(u2_x[0]);
      f1_pr[3]  <= YP_W'(u2_side.z0) * YP_W'(u2_x[2]);
      f1_pr[4]  <= YP_W'(u2_side.z0) * YP_W'(u2_x[1]);
      f1_pr[5]  <= YP_W'(u2_side.z1) * YP_W'(u2_x[0]);
      f1_x      <= u2_x;
      f1_z[0]   <= u2_side.z0;
      f1_z[1]   <= u2_side.z1;
      f1_z[2]   <= u2_side.z2;
      f1_eye[0] <= u2_side.e0;
      f1_eye[1] <= u2_side.e1;
      f1_eye[2] <= u2_side.e2;
      f1_degen  <= u2_side.zero | u2_zero;
    end
  end

  // stage f2: y differences
  logic                   f2_valid;
  logic signed [YD_W-1:0] f2_yd [3];
  logic signed [Z_W-1:0]  f2_x  [3];
  logic signed [Z_W-1:0]  f2_z  [3];
  logic signed [CW-1:0]   f2_eye [3];
  logic                   f2_degen;

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_valid <= 1'b0;
    end else if (en) begin
      f2_valid <= f1_valid;
    end
    if (en) begin
      f2_yd[0] <= YD_W'(f1_pr[0]) - YD_W'(f1_pr[1]);
      f2_yd[1] <= YD_W'(f1_pr[2]) - YD_W'(f1_pr[3]);
      f2_yd[2] <= YD_W'(f1_pr[4]) - YD_W'(f1_pr[5]);
      f2_x     <= f1_x;
      f2_z     <= f1_z;
      f2_eye   <= f1_eye;
      f2_degen <= f1_degen;
    end
  end

  // stage f3: y rounded, eye split into whole and fraction
  logic signed [YD_W-1:0] y_rnd [3];
  logic signed [EW_W-1:0] eye_w [3];
  logic signed [EW_W-1:0] eye_sh [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      y_rnd[i]  = (f2_yd[i] + HALF_Y) >>> F;
      eye_w[i]  = EW_W'(f2_eye[i]);
      eye_sh[i] = eye_w[i] >>> F;
    end
  end

  logic                  f3_valid;
  logic signed [R_W-1:0] f3_row [3][3];
  logic signed [CW-1:0]  f3_whole [3];
  logic signed [F:0]     f3_rem [3];
  logic                  f3_degen;

  always_ff @(posedge clk) begin
    if (rst) begin
      f3_valid <= 1'b0;
    end else if (en) begin
      f3_valid <= f2_valid;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        f3_row[0][i] <= R_W'(f2_x[i]);
        f3_row[1][i] <= y_rnd[i][R_W-1:0];
        f3_row[2][i] <= R_W'(f2_z[i]);
        f3_whole[i]  <= eye_sh[i][CW-1:0];
        f3_rem[i]    <= {1'b0, eye_w[i][F-1:0]};
      end
      f3_degen <= f2_degen;
    end
  end

  // stage g1: translation products
  logic                   g1_valid;
  logic signed [WP_W-1:0] g1_wp [3][3];
  logic signed [FP_W-1:0] g1_fp [3][3];
  logic signed [R_W-1:0]  g1_row [3][3];
  logic                   g1_degen;

  always_ff @(posedge clk) begin
    if (rst) begin
      g1_valid <= 1'b0;
    end else if (en) begin
      g1_valid <= f3_valid;
    end
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          g1_wp[k][i] <= WP_W'(f3_row[k][i]) * WP_W'(f3_whole[i]);
          g1_fp[k][i] <= FP_W'(f3_row[k][i]) * FP_W'(f3_rem[i]);
        end
      end
      g1_row   <= f3_row;
      g1_degen <= f3_degen;
    end
  end

  // stage g2: dot product sums
  logic                   g2_valid;
  logic signed [WS_W-1:0] g2_ws [3];
  logic signed [FS_W-1:0] g2_fs [3];
  logic signed [R_W-1:0]  g2_row [3][3];
  logic                   g2_degen;

  always_ff @(posedge clk) begin
    if (rst) begin
      g2_valid <= 1'b0;
    end else if (en) begin
      g2_valid <= g1_valid;
    end
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        g2_ws[k] <= WS_W'(g1_wp[k][0]) + WS_W'(g1_wp[k][1]) + WS_W'(g1_wp[k][2]);
        g2_fs[k] <= FS_W'(g1_fp[k][0]) + FS_W'(g1_fp[k][1]) + FS_W'(g1_fp[k][2]);
      end
      g2_row   <= g1_row;
      g2_degen <= g1_degen;
    end
  end

  // stage g3: fraction part rounded
  logic                   g3_valid;
  logic signed [WS_W-1:0] g3_ws [3];
  logic signed [FS_W-1:0] g3_fr [3];
  logic signed [R_W-1:0]  g3_row [3][3];
  logic                   g3_degen;

  always_ff @(posedge clk) begin
    if (rst) begin
      g3_valid <= 1'b0;
    end else if (en) begin
      g3_valid <= g2_valid;
    end
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        g3_fr[k] <= (g2_fs[k] + HALF_F) >>> F;
      end
      g3_ws    <= g2_ws;
      g3_row   <= g2_row;
      g3_degen <= g2_degen;
    end
  end

  // stage g4: negated translation
  logic                  g4_valid;
  logic signed [T_W-1:0] g4_t [3];
  logic signed [R_W-1:0] g4_row [3][3];
  logic                  g4_degen;

  always_ff @(posedge clk) begin
    if (rst) begin
      g4_valid <= 1'b0;
    end else if (en) begin
      g4_valid <= g3_valid;
    end
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        g4_t[k] <= -(T_W'(g3_ws[k]) + T_W'(g3_fr[k]));
      end
      g4_row   <= g3_row;
      g4_degen <= g3_degen;
    end
  end

  // clamp to the coordinate range
  logic signed [T_W-1:0] raw_v [13];
  logic signed [T_W-1:0] cl_v  [13];
  logic [12:0]           hit;
  logic [31:0]           ld_ent [4][4];
  logic                  ld_sat;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      raw_v[k]     = T_W'(g4_row[0][k]);
      raw_v[3+k]   = T_W'(g4_row[1][k]);
      raw_v[6+k]   = T_W'(g4_row[2][k]);
      raw_v[9+k]   = g4_t[k];
    end
    raw_v[12] = ONE_T;
    for (int i = 0; i < 13; i++) begin
      hit[i] = (raw_v[i] > HI_T) || (raw_v[i] < LO_T);
      if (raw_v[i] > HI_T) begin
        cl_v[i] = HI_T;
      end else if (raw_v[i] < LO_T) begin
        cl_v[i] = LO_T;
      end else begin
        cl_v[i] = raw_v[i];
      end
    end
    for (int k = 0; k < 3; k++) begin
      ld_ent[k][0] = cl_v[k][31:0];
      ld_ent[k][1] = cl_v[3+k][31:0];
      ld_ent[k][2] = cl_v[6+k][31:0];
      ld_ent[k][3] = '0;
      ld_ent[3][k] = cl_v[9+k][31:0];
    end
    ld_ent[3][3] = cl_v[12][31:0];
    ld_sat = |hit;
  end

  // column output register
  logic        s_valid;
  logic [1:0]  s_col;
  logic [31:0] s_ent [4][4];
  logic        s_degen;
  logic        s_sat;

  assign ser_free   = !s_valid || (!column_stall && (s_col == LAST_COL));
  assign en         = !g4_valid || ser_free;
  assign item_stall = !en || rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
      s_col   <= '0;
    end else begin
      if (s_valid && !column_stall) s_col <= s_col + 2'd1;
      if (ser_free) s_valid <= g4_valid;
    end
    if (ser_free && g4_valid) begin
      s_ent   <= ld_ent;
      s_degen <= g4_degen;
      s_sat   <= ld_sat;
    end
  end

  assign column_valid = s_valid;
  assign column_index = s_col;
  assign entry_row0   = s_ent[s_col][0];
  assign entry_row1   = s_ent[s_col][1];
  assign entry_row2   = s_ent[s_col][2];
  assign entry_row3   = s_ent[s_col][3];
  assign degenerate   = s_degen;
  assign saturated    = s_sat;
  assign last_column  = (s_col == LAST_COL);

endmodule
